>>> rtl/dvr_pkg.sv
// Shared types and constants for the distance-vector route update block.
// No dependencies.
package dvr_pkg;

  localparam int NODE_COUNT_DEF = 64;
  localparam int PORT_COUNT_DEF = 8;
  localparam int INF_COST_DEF   = 16;

  localparam int NODE_W     = 6;
  localparam int COST_W     = 5;
  localparam int PORT_W     = 3;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd5;

  typedef enum logic [1:0] {
    REQ_HELLO  = 2'd0,
    REQ_ADVERT = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_QUERY  = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SELF_NODE        = 1'b0,
    CFG_NEIGHBOR_TIMEOUT = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ADV_APPLY,
    ST_ADV_SWEEP,
    ST_TICK_NB,
    ST_TICK_RT,
    ST_Q_NB,
    ST_Q_OUT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic upd;
    logic set_pres;
    logic clr_pres;
    logic chg;
  } cost_dec_t;

endpackage

>>> rtl/dvr_cost_unit.sv
// Advert entry decision: saturated cost plus one against the current route.
// Depends on dvr_pkg.
module dvr_cost_unit #(
  parameter int INFINITE_COST = dvr_pkg::INF_COST_DEF,
  parameter int MW            = 6
) (
  input  logic [dvr_pkg::COST_W-1:0] adv_cost_i,
  input  logic                       present_i,
  input  logic                       hop_eq_i,
  input  logic [MW-1:0]              metric_i,
  output logic [MW-1:0]              new_metric_o,
  output dvr_pkg::cost_dec_t         dec_o
);
  import dvr_pkg::*;

  localparam logic [MW-1:0] INF = MW'(INFINITE_COST);

  logic [MW-1:0] sum;
  logic          inf;

  assign sum          = MW'(adv_cost_i) + MW'(1);
  assign new_metric_o = (sum > INF) ? INF : sum;
  assign inf          = (new_metric_o >= INF);

  always_comb begin
    dec_o = '0;
    if (!present_i) begin
      if (!inf) begin
        dec_o.upd      = 1'b1;
        dec_o.set_pres = 1'b1;
        dec_o.chg      = 1'b1;
      end
    end else if (hop_eq_i) begin
      if (inf) begin
        dec_o.clr_pres = 1'b1;
        dec_o.chg      = 1'b1;
      end else if (metric_i != new_metric_o) begin
        dec_o.upd = 1'b1;
        dec_o.chg = 1'b1;
      end
    end else if (new_metric_o < metric_i) begin
      dec_o.upd = 1'b1;
      dec_o.chg = 1'b1;
    end
  end

endmodule

>>> rtl/distance_vector_route_update_top.sv
// Top level of the distance-vector route update block: sequencer, tables.
// Depends on dvr_pkg and dvr_cost_unit.
// One item at a time: busy is high from accept to the done_o strobe. A query
// with a route passes a neighbor lookup state and an output state; a last
// advert entry from a neighbor adds one route-table sweep, one entry per cycle
// through the route memory read port. A tick does a neighbor sweep then a
// route sweep. Each result is shown for one cycle on done_o and cannot be held.
module distance_vector_route_update_top #(
  parameter int NODE_COUNT    = dvr_pkg::NODE_COUNT_DEF,
  parameter int PORT_COUNT    = dvr_pkg::PORT_COUNT_DEF,
  parameter int INFINITE_COST = dvr_pkg::INF_COST_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     req_type_i,
  input  logic [dvr_pkg::NODE_W-1:0]     sender_node_i,
  input  logic [dvr_pkg::NODE_W-1:0]     dest_node_i,
  input  logic [dvr_pkg::COST_W-1:0]     adv_cost_i,
  input  logic                           has_entry_i,
  input  logic                           last_entry_i,
  input  logic [dvr_pkg::PORT_W-1:0]     interface_index_i,
  input  logic                           cfg_we_i,
  input  logic [dvr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dvr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                           done_o,
  output logic                           table_changed_o,
  output logic                           advert_ignored_o,
  output logic                           route_valid_o,
  output logic [dvr_pkg::NODE_W-1:0]     route_next_hop_o,
  output logic [dvr_pkg::COST_W-1:0]     route_cost_o,
  output logic [dvr_pkg::PORT_W-1:0]     route_interface_o
);
  import dvr_pkg::*;

  localparam int NIDX  = $clog2(NODE_COUNT);
  localparam int CW    = NIDX + 1;
  localparam int MWC   = $clog2(INFINITE_COST + 1);
  localparam int MW    = (MWC > 6) ? MWC : 6;

  state_e state_q, state_d;
  req_e   type_q, type_d;
  logic [NODE_W-1:0] snd_q, snd_d, dst_q, dst_d;
  logic [COST_W-1:0] cost_q, cost_d;
  logic              has_q, has_d, last_q, last_d;
  logic [PORT_W-1:0] port_q, port_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [TIME_W-1:0] tick_q, tick_d, tmo_q, tmo_d;
  logic [NODE_W-1:0] self_q, self_d;
  logic [NODE_COUNT-1:0] rt_pres_q, rt_pres_d, nb_pres_q, nb_pres_d;
  logic [NODE_COUNT-1:0] seen_q, seen_d, exp_q, exp_d;
  logic              adv_chg_q, adv_chg_d;
  logic              chg_q, chg_d, ign_q, ign_d, vld_q, vld_d;
  logic [NODE_W-1:0] hop_q, hop_d;
  logic [COST_W-1:0] met_q, met_d;
  logic [PORT_W-1:0] intf_q, intf_d;

  logic [NODE_W-1:0] rt_hop_mem [NODE_COUNT];
  logic [MW-1:0]     rt_met_mem [NODE_COUNT];
  logic [TIME_W-1:0] nb_time_mem [NODE_COUNT];
  logic [PORT_W-1:0] nb_port_mem [NODE_COUNT];
  logic [NODE_W-1:0] rt_hop_rd_q;
  logic [MW-1:0]     rt_met_rd_q;
  logic [TIME_W-1:0] nb_time_rd_q;
  logic [PORT_W-1:0] nb_port_rd_q;

  logic              rt_we, nb_time_we, nb_port_we;
  logic [NIDX-1:0]   rt_wa, rt_ra, nb_wa, nb_ra;
  logic [NODE_W-1:0] rt_wd_hop;
  logic [MW-1:0]     rt_wd_met;

  logic            snd_ok, dst_ok, port_ok, hop_ok, cnt_last;
  logic [NIDX-1:0] sidx, didx, cnt_idx, chk_idx, hidx;
  logic [MW-1:0]   new_met;
  cost_dec_t       dec;
  logic            sweep_clr;

  assign sidx     = NIDX'(snd_q);
  assign didx     = NIDX'(dst_q);
  assign snd_ok   = 32'(snd_q) < NODE_COUNT;
  assign dst_ok   = 32'(dst_q) < NODE_COUNT;
  assign port_ok  = 32'(port_q) < PORT_COUNT;
  assign hidx     = NIDX'(hop_q);
  assign hop_ok   = 32'(hop_q) < NODE_COUNT;
  assign cnt_idx  = cnt_q[NIDX-1:0];
  assign chk_idx  = NIDX'(cnt_q - CW'(1));
  assign cnt_last = (cnt_q == CW'(NODE_COUNT));

  dvr_cost_unit #(
    .INFINITE_COST(INFINITE_COST),
    .MW           (MW)
  ) u_cost (
    .adv_cost_i  (cost_q),
    .present_i   (rt_pres_q[didx]),
    .hop_eq_i    (rt_hop_rd_q == snd_q),
    .metric_i    (rt_met_rd_q),
    .new_metric_o(new_met),
    .dec_o       (dec)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (type_q)
          REQ_HELLO: state_d = ST_DONE;
          REQ_ADVERT: begin
            if (!snd_ok || !nb_pres_q[sidx]) state_d = ST_DONE;
            else if (has_q && dst_ok && dst_q != self_q) state_d = ST_ADV_APPLY;
            else if (last_q) state_d = ST_ADV_SWEEP;
            else state_d = ST_DONE;
          end
          REQ_TICK: state_d = ST_TICK_NB;
          REQ_QUERY: state_d = (dst_ok && rt_pres_q[didx]) ? ST_Q_NB : ST_DONE;
          default: state_d = ST_DONE;
        endcase
      end
      ST_ADV_APPLY: state_d = last_q ? ST_ADV_SWEEP : ST_DONE;
      ST_ADV_SWEEP: if (cnt_last) state_d = ST_DONE;
      ST_TICK_NB:   if (cnt_last) state_d = ST_TICK_RT;
      ST_TICK_RT:   if (cnt_last) state_d = ST_DONE;
      ST_Q_NB:      state_d = ST_Q_OUT;
      ST_Q_OUT:     state_d = ST_DONE;
      ST_DONE:      state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // datapath and table control
  always_comb begin
    type_d = type_q; snd_d = snd_q; dst_d = dst_q; cost_d = cost_q;
    has_d = has_q; last_d = last_q; port_d = port_q;
    cnt_d = cnt_q; tick_d = tick_q; tmo_d = tmo_q; self_d = self_q;
    rt_pres_d = rt_pres_q; nb_pres_d = nb_pres_q; seen_d = seen_q; exp_d = exp_q;
    adv_chg_d = adv_chg_q;
    chg_d = chg_q; ign_d = ign_q; vld_d = vld_q;
    hop_d = hop_q; met_d = met_q; intf_d = intf_q;
    rt_we = 1'b0; nb_time_we = 1'b0; nb_port_we = 1'b0;
    rt_wa = sidx; rt_ra = didx; nb_wa = sidx; nb_ra = sidx;
    rt_wd_hop = snd_q; rt_wd_met = MW'(1);
    sweep_clr = 1'b0;

    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_SELF_NODE:        self_d = cfg_wdata_i[NODE_W-1:0];
        CFG_NEIGHBOR_TIMEOUT: tmo_d  = cfg_wdata_i[TIME_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          type_d = req_e'(req_type_i); snd_d = sender_node_i; dst_d = dest_node_i;
          cost_d = adv_cost_i; has_d = has_entry_i; last_d = last_entry_i;
          port_d = interface_index_i;
        end
      end
      ST_EXEC: begin
        chg_d = 1'b0; ign_d = 1'b0; vld_d = 1'b0;
        hop_d = '0; met_d = '0; intf_d = '0;
        cnt_d = '0;
        case (type_q)
          REQ_HELLO: begin
            if (snd_ok && port_ok) begin
              nb_time_we = 1'b1;
              if (!nb_pres_q[sidx]) begin
                nb_pres_d[sidx] = 1'b1;
                nb_port_we      = 1'b1;
                rt_pres_d[sidx] = 1'b1;
                rt_we           = 1'b1;
                chg_d           = 1'b1;
              end
            end
          end
          REQ_ADVERT: begin
            if (!snd_ok || !nb_pres_q[sidx]) begin
              ign_d = 1'b1;
              if (last_q) begin
                seen_d    = '0;
                adv_chg_d = 1'b0;
              end
            end else begin
              nb_time_we = 1'b1;
              if (has_q && dst_ok) seen_d[didx] = 1'b1;
            end
          end
          REQ_TICK: begin
            tick_d = tick_q + TIME_W'(1);
            exp_d  = '0;
          end
          default: ;
        endcase
      end
      ST_ADV_APPLY: begin
        cnt_d     = '0;
        rt_wa     = didx;
        rt_wd_met = new_met;
        rt_we     = dec.upd;
        if (dec.set_pres) rt_pres_d[didx] = 1'b1;
        if (dec.clr_pres) rt_pres_d[didx] = 1'b0;
        if (dec.chg) adv_chg_d = 1'b1;
      end
      ST_ADV_SWEEP: begin
        rt_ra = cnt_idx;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q != '0 && rt_pres_q[chk_idx] && rt_hop_rd_q == snd_q &&
            !seen_q[chk_idx] && rt_met_rd_q > MW'(1)) begin
          sweep_clr          = 1'b1;
          rt_pres_d[chk_idx] = 1'b0;
        end
        if (cnt_last) begin
          chg_d     = adv_chg_q | sweep_clr;
          seen_d    = '0;
          adv_chg_d = 1'b0;
        end else begin
          adv_chg_d = adv_chg_q | sweep_clr;
        end
      end
      ST_TICK_NB: begin
        nb_ra = cnt_idx;
        cnt_d = cnt_last ? '0 : cnt_q + CW'(1);
        if (cnt_q != '0 && nb_pres_q[chk_idx] &&
            (tick_q - nb_time_rd_q) > tmo_q) begin
          nb_pres_d[chk_idx] = 1'b0;
          exp_d[chk_idx]     = 1'b1;
        end
      end
      ST_TICK_RT: begin
        rt_ra = cnt_idx;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q != '0 && rt_pres_q[chk_idx] && exp_q[NIDX'(rt_hop_rd_q)]) begin
          rt_pres_d[chk_idx] = 1'b0;
          chg_d              = 1'b1;
        end
      end
      ST_Q_NB: begin
        vld_d = 1'b1;
        hop_d = rt_hop_rd_q;
        met_d = COST_W'(rt_met_rd_q);
        nb_ra = NIDX'(rt_hop_rd_q);
      end
      ST_Q_OUT: begin
        if (hop_ok && nb_pres_q[hidx]) intf_d = nb_port_rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rt_we) begin
      rt_hop_mem[rt_wa] <= rt_wd_hop;
      rt_met_mem[rt_wa] <= rt_wd_met;
    end
    if (nb_time_we) nb_time_mem[nb_wa] <= tick_q;
    if (nb_port_we) nb_port_mem[nb_wa] <= port_q;
    rt_hop_rd_q  <= rt_hop_mem[rt_ra];
    rt_met_rd_q  <= rt_met_mem[rt_ra];
    nb_time_rd_q <= nb_time_mem[nb_ra];
    nb_port_rd_q <= nb_port_mem[nb_ra];
  end

  always_ff @(posedge clk_i) begin
    type_q <= type_d; snd_q <= snd_d; dst_q <= dst_d; cost_q <= cost_d;
    has_q <= has_d; last_q <= last_d; port_q <= port_d;
    chg_q <= chg_d; ign_q <= ign_d; vld_q <= vld_d;
    hop_q <= hop_d; met_q <= met_d; intf_q <= intf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      tick_q    <= '0;
      tmo_q     <= TIMEOUT_RST;
      self_q    <= '0;
      rt_pres_q <= '0;
      nb_pres_q <= '0;
      seen_q    <= '0;
      exp_q     <= '0;
      adv_chg_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      tick_q    <= tick_d;
      tmo_q     <= tmo_d;
      self_q    <= self_d;
      rt_pres_q <= rt_pres_d;
      nb_pres_q <= nb_pres_d;
      seen_q    <= seen_d;
      exp_q     <= exp_d;
      adv_chg_q <= adv_chg_d;
    end
  end

  assign busy              = (state_q != ST_IDLE);
  assign done_o            = (state_q == ST_DONE);
  assign table_changed_o   = chg_q;
  assign advert_ignored_o  = ign_q;
  assign route_valid_o     = vld_q;
  assign route_next_hop_o  = hop_q;
  assign route_cost_o      = met_q;
  assign route_interface_o = intf_q;

endmodule

>>> rtl/dvr_checker.sv
// Port-level checks for the route update top level, bound to it below.
// Depends on dvr_pkg.
module dvr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       done_o,
  input logic                       advert_ignored_o,
  input logic                       route_valid_o,
  input logic                       table_changed_o
);
  import dvr_pkg::*;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done outside busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("item accepted but not busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done strobe longer than one cycle");

  a_result_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(advert_ignored_o && (route_valid_o || table_changed_o)))
    else $error("conflicting result flags");

endmodule

bind distance_vector_route_update_top dvr_checker u_dvr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .advert_ignored_o(advert_ignored_o),
  .route_valid_o   (route_valid_o),
  .table_changed_o (table_changed_o)
);

>>> test/tb.sv
// Self-checking testbench for distance_vector_route_update_top: directed table, then
// random hello/advert/tick/query traffic checked against an in-bench route table model.
// Depends on dvr_pkg and the RTL of the block.
module tb;
  import dvr_pkg::*;

  typedef struct packed {
    logic                changed;
    logic                ignored;
    logic                valid;
    logic [NODE_W-1:0]   hop;
    logic [COST_W-1:0]   cost;
    logic [PORT_W-1:0]   intf;
  } route_rsp_t;

  typedef struct packed {
    req_e                kind;
    logic [NODE_W-1:0]   sender;
    logic [NODE_W-1:0]   dest;
    logic [COST_W-1:0]   cost;
    logic                has_entry;
    logic                last;
    logic [PORT_W-1:0]   intf;
  } route_req_t;

  typedef struct packed {
    route_req_t req;
    logic       typed;
    route_rsp_t rsp;
  } table_row_t;

  localparam int NODES = NODE_COUNT_DEF;
  localparam int INF   = INF_COST_DEF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type_i = '0;
  logic [NODE_W-1:0] sender_node_i = '0;
  logic [NODE_W-1:0] dest_node_i = '0;
  logic [COST_W-1:0] adv_cost_i = '0;
  logic has_entry_i = 1'b0;
  logic last_entry_i = 1'b0;
  logic [PORT_W-1:0] interface_index_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic done_o;
  logic table_changed_o, advert_ignored_o, route_valid_o;
  logic [NODE_W-1:0] route_next_hop_o;
  logic [COST_W-1:0] route_cost_o;
  logic [PORT_W-1:0] route_interface_o;

  distance_vector_route_update_top DUT (.*);

  always #5 clk_i = ~clk_i;

  // route and neighbor table copy
  logic              rt_pres [NODES];
  logic [NODE_W-1:0] rt_hop  [NODES];
  logic [COST_W-1:0] rt_cost [NODES];
  logic              nb_pres [NODES];
  logic [31:0]       nb_heard[NODES];
  logic [PORT_W-1:0] nb_port [NODES];
  logic              adv_seen[NODES];
  logic              adv_chg;
  logic [31:0]       ticks;
  logic [NODE_W-1:0] self_id;
  logic [31:0]       nb_timeout;

  route_rsp_t pending_rsp[$];
  int errors = 0;
  int n_items = 0;
  int n_rsp = 0;

  function automatic void clear_advert();
    foreach (adv_seen[i]) adv_seen[i] = 1'b0;
    adv_chg = 1'b0;
  endfunction

  function automatic void apply_advert_entry(int from, int d, int c_in);
    int c;
    c = c_in + 1;
    if (c > INF) c = INF;
    if (!rt_pres[d]) begin
      if (c < INF) begin
        rt_pres[d] = 1'b1; rt_hop[d] = NODE_W'(from); rt_cost[d] = COST_W'(c);
        adv_chg = 1'b1;
      end
    end else if (rt_hop[d] == from) begin
      if (c >= INF) begin
        rt_pres[d] = 1'b0; adv_chg = 1'b1;
      end else if (rt_cost[d] != c) begin
        rt_cost[d] = COST_W'(c); adv_chg = 1'b1;
      end
    end else if (c < rt_cost[d]) begin
      rt_hop[d] = NODE_W'(from); rt_cost[d] = COST_W'(c); adv_chg = 1'b1;
    end
  endfunction

  function automatic route_rsp_t update_routes(route_req_t r);
    route_rsp_t o;
    o = '0;
    case (r.kind)
      REQ_HELLO: begin
        if (nb_pres[r.sender]) begin
          nb_heard[r.sender] = ticks;
        end else begin
          nb_pres[r.sender] = 1'b1; nb_port[r.sender] = r.intf;
          nb_heard[r.sender] = ticks;
          rt_pres[r.sender] = 1'b1; rt_hop[r.sender] = r.sender;
          rt_cost[r.sender] = COST_W'(1);
          o.changed = 1'b1;
        end
      end
      REQ_ADVERT: begin
        if (!nb_pres[r.sender]) begin
          o.ignored = 1'b1;
          if (r.last) clear_advert();
        end else begin
          nb_heard[r.sender] = ticks;
          if (r.has_entry) begin
            adv_seen[r.dest] = 1'b1;
            if (r.dest != self_id) apply_advert_entry(r.sender, r.dest, r.cost);
          end
          if (r.last) begin
            for (int d = 0; d < NODES; d++)
              if (rt_pres[d] && rt_hop[d] == r.sender && !adv_seen[d] && rt_cost[d] > 1) begin
                rt_pres[d] = 1'b0; adv_chg = 1'b1;
              end
            o.changed = adv_chg;
            clear_advert();
          end
        end
      end
      REQ_TICK: begin
        ticks = ticks + 32'd1;
        for (int n = 0; n < NODES; n++)
          if (nb_pres[n] && (ticks - nb_heard[n]) > nb_timeout) begin
            for (int d = 0; d < NODES; d++)
              if (rt_pres[d] && rt_hop[d] == n) begin
                rt_pres[d] = 1'b0; o.changed = 1'b1;
              end
            nb_pres[n] = 1'b0;
          end
      end
      default: begin
        if (rt_pres[r.dest]) begin
          o.valid = 1'b1; o.hop = rt_hop[r.dest]; o.cost = rt_cost[r.dest];
          if (nb_pres[rt_hop[r.dest]]) o.intf = nb_port[rt_hop[r.dest]];
        end
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("%0t: mismatch on %s: got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin
    route_rsp_t w;
    if (rst_ni && done_o) begin
      n_rsp++;
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: result with no item outstanding", $time);
      end else begin
        w = pending_rsp.pop_front();
        if (table_changed_o !== w.changed) report_mismatch("table_changed", table_changed_o, w.changed);
        if (advert_ignored_o !== w.ignored) report_mismatch("advert_ignored", advert_ignored_o, w.ignored);
        if (route_valid_o !== w.valid) report_mismatch("route_valid", route_valid_o, w.valid);
        if (route_next_hop_o !== w.hop) report_mismatch("route_next_hop", route_next_hop_o, w.hop);
        if (route_cost_o !== w.cost) report_mismatch("route_cost", route_cost_o, w.cost);
        if (route_interface_o !== w.intf) report_mismatch("route_interface", route_interface_o, w.intf);
      end
    end
  end

  task automatic send_item(route_req_t r, logic typed, route_rsp_t want);
    route_rsp_t p;
    bit acc;
    if ($urandom_range(0, 2) != 0) begin
      start = 1'b0;
      repeat ($urandom_range(0, 13)) @(negedge clk_i);
    end
    start = 1'b1;
    req_type_i = r.kind; sender_node_i = r.sender; dest_node_i = r.dest;
    adv_cost_i = r.cost; has_entry_i = r.has_entry; last_entry_i = r.last;
    interface_index_i = r.intf;
    acc = 0;
    while (!acc) begin
      @(posedge clk_i);
      acc = !busy;
      if (acc) begin
        p = update_routes(r);
        pending_rsp.push_back(typed ? want : p);
        n_items++;
      end
      @(negedge clk_i);
    end
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_SELF_NODE) self_id = val[NODE_W-1:0];
    else nb_timeout = val;
  endtask

  function automatic logic [NODE_W-1:0] pick_node();
    if ($urandom_range(0, 9) == 0) return NODE_W'($urandom_range(0, 63));
    return NODE_W'($urandom_range(0, 7));
  endfunction

  function automatic route_req_t rand_item();
    route_req_t r;
    int k;
    r = '0;
    r.sender = pick_node();
    r.dest = pick_node();
    r.intf = PORT_W'($urandom_range(0, 7));
    r.has_entry = ($urandom_range(0, 9) != 0);
    r.last = ($urandom_range(0, 3) == 0);
    r.cost = ($urandom_range(0, 7) == 0) ? COST_W'($urandom_range(0, 31))
                                         : COST_W'($urandom_range(0, 16));
    k = $urandom_range(0, 99);
    if (k < 20) r.kind = REQ_HELLO;
    else if (k < 65) r.kind = REQ_ADVERT;
    else if (k < 75) r.kind = REQ_TICK;
    else r.kind = REQ_QUERY;
    return r;
  endfunction

  table_row_t directed[$];

  function automatic table_row_t row(req_e k, int s, int d, int c, bit he, bit l, int i,
                                     bit typed, route_rsp_t w);
    table_row_t t;
    t.req = '{kind: k, sender: NODE_W'(s), dest: NODE_W'(d), cost: COST_W'(c),
              has_entry: he, last: l, intf: PORT_W'(i)};
    t.typed = typed;
    t.rsp = w;
    return t;
  endfunction

  initial begin
    route_rsp_t z;
    z = '0;
    foreach (rt_pres[i]) begin
      rt_pres[i] = 0; rt_hop[i] = 0; rt_cost[i] = 0;
      nb_pres[i] = 0; nb_heard[i] = 0; nb_port[i] = 0;
    end
    clear_advert();
    ticks = 0; self_id = 0; nb_timeout = TIMEOUT_RST;

    directed.push_back(row(REQ_QUERY, 0, 5, 0, 0, 0, 0, 1, z));
    directed.push_back(row(REQ_ADVERT, 3, 9, 2, 1, 1, 0, 1,
                           '{1'b0, 1'b1, 1'b0, 6'd0, 5'd0, 3'd0}));
    directed.push_back(row(REQ_HELLO, 3, 0, 0, 0, 0, 7, 1,
                           '{1'b1, 1'b0, 1'b0, 6'd0, 5'd0, 3'd0}));
    directed.push_back(row(REQ_HELLO, 3, 0, 0, 0, 0, 2, 1, z));
    directed.push_back(row(REQ_QUERY, 0, 3, 0, 0, 0, 0, 1,
                           '{1'b0, 1'b0, 1'b1, 6'd3, 5'd1, 3'd7}));
    directed.push_back(row(REQ_ADVERT, 3, 10, 0, 1, 0, 0, 0, z));
    directed.push_back(row(REQ_ADVERT, 3, 11, 15, 1, 0, 0, 0, z));
    directed.push_back(row(REQ_ADVERT, 3, 0, 2, 1, 0, 0, 0, z));
    directed.push_back(row(REQ_ADVERT, 3, 12, 31, 1, 0, 0, 0, z));
    directed.push_back(row(REQ_ADVERT, 3, 20, 14, 1, 0, 0, 0, z));
    directed.push_back(row(REQ_ADVERT, 3, 0, 0, 0, 1, 0, 0, z));
    directed.push_back(row(REQ_QUERY, 0, 20, 0, 0, 0, 0, 0, z));
    directed.push_back(row(REQ_HELLO, 63, 0, 0, 0, 0, 0, 0, z));
    directed.push_back(row(REQ_HELLO, 0, 0, 0, 0, 0, 5, 0, z));
    directed.push_back(row(REQ_ADVERT, 63, 10, 0, 1, 1, 0, 0, z));
    directed.push_back(row(REQ_ADVERT, 63, 20, 1, 1, 1, 0, 0, z));
    directed.push_back(row(REQ_ADVERT, 3, 63, 14, 1, 0, 0, 0, z));
    directed.push_back(row(REQ_ADVERT, 5, 1, 1, 1, 1, 0, 0, z));
    directed.push_back(row(REQ_ADVERT, 3, 10, 16, 1, 1, 0, 0, z));
    directed.push_back(row(REQ_QUERY, 0, 20, 0, 0, 0, 0, 0, z));
    for (int i = 0; i < 6; i++) directed.push_back(row(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, z));
    directed.push_back(row(REQ_QUERY, 0, 63, 0, 0, 0, 0, 0, z));

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_item(directed[i].req, directed[i].typed, directed[i].rsp);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_reg(CFG_SELF_NODE, 63); write_reg(CFG_NEIGHBOR_TIMEOUT, 0); end
        1: begin write_reg(CFG_SELF_NODE, 0); write_reg(CFG_NEIGHBOR_TIMEOUT, 32'hFFFF_FFFF); end
        2: begin write_reg(CFG_SELF_NODE, $urandom_range(0, 7)); write_reg(CFG_NEIGHBOR_TIMEOUT, 2); end
        default: begin write_reg(CFG_SELF_NODE, $urandom_range(0, 63)); write_reg(CFG_NEIGHBOR_TIMEOUT, 5); end
      endcase
      for (int i = 0; i < 205; i++) send_item(rand_item(), 0, z);
      drain();
    end

    $display("covered %0d items and %0d results over four register settings", n_items, n_rsp);
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb failed");
    $finish;
  end
endmodule

>>> sim.f
rtl/dvr_pkg.sv
rtl/dvr_cost_unit.sv
rtl/distance_vector_route_update_top.sv
rtl/dvr_checker.sv
test/tb.sv
